@@ src/uer_pkg.sv @@
// Shared types and constants for the ultrasonic echo ranger.
// No dependencies; every other file in src refers to this package by scoped name.
package uer_pkg;

    localparam int DATA_W       = 16;
    localparam int CFG_IDX_W    = 1;
    localparam int SAMPLE_CNT_W = 3;
    localparam int PHASE_W      = 2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TRIG_TICKS  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CM_PER_TICK = 1'd1;

    localparam logic [DATA_W-1:0] TRIG_TICKS_RST  = 16'd240;
    localparam logic [DATA_W-1:0] CM_PER_TICK_RST = 16'd13422;

    // Per-beat status flags carried down the pipeline
    typedef struct packed {
        logic trig;
        logic busy;
        logic done;
    } flags_t;

    // Stage load strobes for the scaling datapath
    typedef struct packed {
        logic p2_load;
        logic p3_load;
    } pipe_en_t;

endpackage

@@ src/uer_ctrl.sv @@
// Measurement sequencer: trigger pulse, echo wait, echo count and sample sum.
// Depends on uer_pkg. State advances only on an accepted input beat.
module uer_ctrl #(
    parameter int SAMPLES    = 5,
    parameter int COUNT_BITS = 16,
    parameter int SUM_W      = 19
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       accept,
    input  logic                       start_req,
    input  logic                       echo,
    input  logic [uer_pkg::DATA_W-1:0] trig_ticks,
    output uer_pkg::flags_t            flags,
    output logic [SUM_W-1:0]           sum_out
);

    localparam logic [uer_pkg::PHASE_W-1:0] PH_IDLE  = 2'd0;
    localparam logic [uer_pkg::PHASE_W-1:0] PH_TRIG  = 2'd1;
    localparam logic [uer_pkg::PHASE_W-1:0] PH_WAIT  = 2'd2;
    localparam logic [uer_pkg::PHASE_W-1:0] PH_COUNT = 2'd3;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    logic [uer_pkg::PHASE_W-1:0]      phase_reg, phase_next;
    logic [uer_pkg::DATA_W-1:0]       pulse_timer_reg, pulse_timer_next;
    logic [COUNT_BITS-1:0]            echo_ticks_reg, echo_ticks_next;
    logic [SUM_W-1:0]                 tick_sum_reg, tick_sum_next;
    logic [uer_pkg::SAMPLE_CNT_W-1:0] sample_number_reg, sample_number_next;

    logic [uer_pkg::DATA_W-1:0]       pulse_len;
    logic [uer_pkg::DATA_W-1:0]       pulse_inc;
    logic [uer_pkg::SAMPLE_CNT_W-1:0] sample_inc;
    logic                             last_sample;

    // A zero trigger length behaves as one tick
    assign pulse_len   = (trig_ticks == '0) ? uer_pkg::DATA_W'(1) : trig_ticks;
    assign pulse_inc   = pulse_timer_reg + uer_pkg::DATA_W'(1);
    assign sample_inc  = sample_number_reg + uer_pkg::SAMPLE_CNT_W'(1);
    assign last_sample = ({1'b0, sample_inc} >= (uer_pkg::SAMPLE_CNT_W + 1)'(SAMPLES))
                         || (sample_inc == '0);

    always_comb
    begin
        phase_next         = phase_reg;
        pulse_timer_next   = pulse_timer_reg;
        echo_ticks_next    = echo_ticks_reg;
        tick_sum_next      = tick_sum_reg;
        sample_number_next = sample_number_reg;
        flags              = '0;
        case (phase_reg)
            PH_TRIG:
            begin
                flags.trig = 1'b1;
                flags.busy = 1'b1;
                if (pulse_inc >= pulse_len)
                begin
                    pulse_timer_next = '0;
                    phase_next       = PH_WAIT;
                end
                else
                begin
                    pulse_timer_next = pulse_inc;
                end
            end
            PH_WAIT:
            begin
                flags.busy = 1'b1;
                if (echo)
                begin
                    echo_ticks_next = COUNT_BITS'(1);
                    phase_next      = PH_COUNT;
                end
            end
            PH_COUNT:
            begin
                if (echo)
                begin
                    flags.busy = 1'b1;
                    if (echo_ticks_reg != COUNT_MAX)
                    begin
                        echo_ticks_next = echo_ticks_reg + COUNT_BITS'(1);
                    end
                end
                else
                begin
                    tick_sum_next      = tick_sum_reg + SUM_W'(echo_ticks_reg);
                    echo_ticks_next    = '0;
                    sample_number_next = sample_inc;
                    if (last_sample)
                    begin
                        flags.done = 1'b1;
                        phase_next = PH_IDLE;
                    end
                    else
                    begin
                        flags.busy       = 1'b1;
                        pulse_timer_next = '0;
                        phase_next       = PH_TRIG;
                    end
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
                if (start_req)
                begin
                    flags.busy         = 1'b1;
                    tick_sum_next      = '0;
                    sample_number_next = '0;
                    pulse_timer_next   = '0;
                    echo_ticks_next    = '0;
                    phase_next         = PH_TRIG;
                end
            end
        endcase
    end

    assign sum_out = tick_sum_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= PH_IDLE;
            pulse_timer_reg   <= '0;
            echo_ticks_reg    <= '0;
            tick_sum_reg      <= '0;
            sample_number_reg <= '0;
        end
        else if (accept)
        begin
            phase_reg         <= phase_next;
            pulse_timer_reg   <= pulse_timer_next;
            echo_ticks_reg    <= echo_ticks_next;
            tick_sum_reg      <= tick_sum_next;
            sample_number_reg <= sample_number_next;
        end
    end

endmodule

@@ src/uer_scale.sv @@
// Distance scaling datapath: sum times cm_per_tick, rounding, divide by the sample count.
// Depends on uer_pkg. Two registered stages; the final quotient feeds the output register.
module uer_scale #(
    parameter int SAMPLES = 5,
    parameter int SUM_W   = 19
) (
    input  logic                       clk,
    input  uer_pkg::pipe_en_t          en,
    input  logic [SUM_W-1:0]           sum_in,
    input  logic [uer_pkg::DATA_W-1:0] cm_per_tick,
    output logic [uer_pkg::DATA_W-1:0] dist_q8
);

    localparam int PROD_W      = SUM_W + uer_pkg::DATA_W;
    localparam int Y_W         = SUM_W + 1;
    localparam int RECIP_SHIFT = Y_W + 3;
    localparam int RECIP_W     = RECIP_SHIFT + 1;
    localparam int QP_W        = Y_W + RECIP_W;
    localparam logic [63:0] RECIP_FULL =
        ((64'd1 << RECIP_SHIFT) + 64'(SAMPLES) - 64'd1) / 64'(SAMPLES);
    localparam logic [RECIP_W-1:0] RECIP = RECIP_FULL[RECIP_W-1:0];
    localparam logic [PROD_W:0] HALF = (PROD_W + 1)'(64'(SAMPLES) << 15);
    localparam logic [63:0] SAT_LIMIT = 64'(SAMPLES) << 16;

    logic [PROD_W-1:0] prod_reg;
    logic [Y_W-1:0]    y_reg;
    logic [PROD_W:0]   rounded;
    logic [QP_W-1:0]   quot_full;
    logic              sat;

    assign rounded = {1'b0, prod_reg} + HALF;

    always_ff @(posedge clk)
    begin
        if (en.p2_load)
        begin
            prod_reg <= PROD_W'(sum_in) * PROD_W'(cm_per_tick);
        end
        if (en.p3_load)
        begin
            y_reg <= Y_W'(rounded >> 16);
        end
    end

    // Divide by the sample count through a reciprocal; exact over the range of y
    assign quot_full = QP_W'(y_reg) * QP_W'(RECIP);
    assign sat       = (64'(y_reg) >= SAT_LIMIT);
    assign dist_q8   = sat ? '1 : uer_pkg::DATA_W'(quot_full >> RECIP_SHIFT);

endmodule

@@ src/ultrasonic_echo_ranger.sv @@
// Top level of the ultrasonic echo ranger: configuration registers, beat pipeline,
// output register. Depends on uer_pkg, uer_ctrl and uer_scale.
//
// Usage
//   Input channel (in_valid / in_stall): one beat per clock tick of the sensor,
//   carrying start_req and the sampled echo level. A beat is taken on a rising
//   edge with in_valid high and in_stall low.
//   Output channel (out_valid / out_stall): exactly one result beat per input
//   beat, in order: trig level, busy_res, done_res and the Q8 centimetre distance.
//   Configuration: wr_en / wr_index / wr_data write trig_ticks (index 0) or
//   cm_per_tick (index 1); write only while no beat is in flight.
// Pipeline and throughput
//   One input beat per cycle while in_stall is low. The sequencer updates its state in the accept cycle;
//   the result then passes the multiply stage, the rounding stage and the divide
//   into the output register. The product and the reciprocal divide each own one stage.
// Reset
//   rst_n clears the sequencer to idle, empties the pipeline, zeroes distance and
//   loads the register defaults (240 ticks, 13422 Q24 cm per tick).
// Stall
//   A stalled result holds in the output register; beats behind it keep moving
//   until each stage is full, and only then does in_stall rise.
module ultrasonic_echo_ranger #(
    parameter int SAMPLES    = 5,
    parameter int COUNT_BITS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          start_req,
    input  logic                          echo,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          trig,
    output logic                          busy_res,
    output logic                          done_res,
    output logic [uer_pkg::DATA_W-1:0]    distance,
    input  logic                          wr_en,
    input  logic [uer_pkg::CFG_IDX_W-1:0] wr_index,
    input  logic [uer_pkg::DATA_W-1:0]    wr_data
);

    // Sum of all samples at full count
    localparam int SUM_W = $clog2(SAMPLES * ((1 << COUNT_BITS) - 1) + 1);

    logic [uer_pkg::DATA_W-1:0] trig_ticks_reg;
    logic [uer_pkg::DATA_W-1:0] cm_per_tick_reg;

    logic p1_valid_reg, p2_valid_reg, p3_valid_reg, out_valid_reg;
    uer_pkg::flags_t p1_flags_reg, p2_flags_reg, p3_flags_reg, out_flags_reg;
    logic [SUM_W-1:0] p1_sum_reg;
    logic [uer_pkg::DATA_W-1:0] distance_reg;

    logic in_accept;
    logic out_free, p3_free, p2_free, p1_free;
    logic p1_adv, p2_adv, p3_adv;
    uer_pkg::flags_t   beat_flags;
    logic [SUM_W-1:0]  beat_sum;
    uer_pkg::pipe_en_t scale_en;
    logic [uer_pkg::DATA_W-1:0] scaled_dist;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            trig_ticks_reg  <= uer_pkg::TRIG_TICKS_RST;
            cm_per_tick_reg <= uer_pkg::CM_PER_TICK_RST;
        end
        else if (wr_en)
        begin
            case (wr_index)
                uer_pkg::REG_TRIG_TICKS:  trig_ticks_reg  <= wr_data;
                uer_pkg::REG_CM_PER_TICK: cm_per_tick_reg <= wr_data;
                default: ;
            endcase
        end
    end

    // Stage handshake: a stage moves on when the next one is empty or moving too
    assign out_free  = !out_valid_reg || !out_stall;
    assign p3_adv    = p3_valid_reg && out_free;
    assign p3_free   = !p3_valid_reg || out_free;
    assign p2_adv    = p2_valid_reg && p3_free;
    assign p2_free   = !p2_valid_reg || p3_free;
    assign p1_adv    = p1_valid_reg && p2_free;
    assign p1_free   = !p1_valid_reg || p2_free;
    assign in_stall  = !p1_free;
    assign in_accept = in_valid && p1_free;

    uer_ctrl #(
        .SAMPLES    (SAMPLES),
        .COUNT_BITS (COUNT_BITS),
        .SUM_W      (SUM_W)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (in_accept),
        .start_req  (start_req),
        .echo       (echo),
        .trig_ticks (trig_ticks_reg),
        .flags      (beat_flags),
        .sum_out    (beat_sum)
    );

    assign scale_en.p2_load = p1_adv;
    assign scale_en.p3_load = p2_adv;

    uer_scale #(
        .SAMPLES (SAMPLES),
        .SUM_W   (SUM_W)
    ) u_scale (
        .clk         (clk),
        .en          (scale_en),
        .sum_in      (p1_sum_reg),
        .cm_per_tick (cm_per_tick_reg),
        .dist_q8     (scaled_dist)
    );

    // Valid bits and the held distance
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_valid_reg  <= 1'b0;
            p2_valid_reg  <= 1'b0;
            p3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            distance_reg  <= '0;
        end
        else
        begin
            if (in_accept)
                p1_valid_reg <= 1'b1;
            else if (p1_adv)
                p1_valid_reg <= 1'b0;

            if (p1_adv)
                p2_valid_reg <= 1'b1;
            else if (p2_adv)
                p2_valid_reg <= 1'b0;

            if (p2_adv)
                p3_valid_reg <= 1'b1;
            else if (p3_adv)
                p3_valid_reg <= 1'b0;

            if (p3_adv)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;

            // Latch a fresh distance only when a done beat enters the output register
            if (p3_adv && p3_flags_reg.done)
                distance_reg <= scaled_dist;
        end
    end

    // Beat payload
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            p1_flags_reg <= beat_flags;
            p1_sum_reg   <= beat_sum;
        end
        if (p1_adv)
            p2_flags_reg <= p1_flags_reg;
        if (p2_adv)
            p3_flags_reg <= p2_flags_reg;
        if (p3_adv)
            out_flags_reg <= p3_flags_reg;
    end

    assign out_valid = out_valid_reg;
    assign trig      = out_flags_reg.trig;
    assign busy_res  = out_flags_reg.busy;
    assign done_res  = out_flags_reg.done;
    assign distance  = distance_reg;

    // A finished sequence is never reported as still running
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(done_res && busy_res))
    else $error("done and busy set on the same result beat");

    // The trigger pin is only driven inside a running sequence
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && trig) |-> busy_res)
    else $error("trig high outside a running sequence");

    // The distance moves only together with a done beat
    assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(distance) |-> (out_valid && done_res))
    else $error("distance changed without a done beat");

    // The input side stalls only when every stage and the output register hold a beat
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (p1_valid_reg && p2_valid_reg && p3_valid_reg && out_valid_reg))
    else $error("input stalled with room in the pipeline");

endmodule

@@ bench/tb_top.sv @@
// Self-checking bench for ultrasonic_echo_ranger: one beat per sensor tick in,
// one status/distance beat out. Depends on uer_pkg and the ranger RTL only.
`timescale 1ns / 1ps

module tb_top;

    localparam int          NUM_SAMPLES     = 5;
    localparam int          ECHO_COUNT_BITS = 16;
    localparam int          HALF_PERIOD     = 2;
    localparam int          RESET_CYCLES    = 7;
    localparam int          SETTLE_CYCLES   = 8;
    localparam int          MAX_REPORTS     = 100;
    // Overall cycle limit for the run, set well above what the tests need with idling and stalls.
    localparam int unsigned CYCLE_LIMIT     = 40_000;

    localparam logic [ECHO_COUNT_BITS-1:0] ECHO_COUNT_MAX = '1;
    localparam longint unsigned            SCALE_DEN      = 64'(NUM_SAMPLES) << 16;

    // Sequencer phases of the predictor
    typedef enum logic [1:0] {
        PH_IDLE,
        PH_TRIGGER,
        PH_WAIT_ECHO,
        PH_COUNT
    } ranger_phase_e;

    // One result beat: pin levels, status flags and the Q8 distance
    typedef struct packed {
        logic                       trig;
        logic                       busy;
        logic                       done;
        logic [uer_pkg::DATA_W-1:0] distance;
    } tick_result_t;

    logic                          clk       = 1'b0;
    logic                          rst_n     = 1'b0;
    logic                          in_valid  = 1'b0;
    logic                          in_stall;
    logic                          start_req = 1'b0;
    logic                          echo      = 1'b0;
    logic                          out_valid;
    logic                          out_stall = 1'b0;
    logic                          trig;
    logic                          busy_res;
    logic                          done_res;
    logic [uer_pkg::DATA_W-1:0]    distance;
    logic                          wr_en     = 1'b0;
    logic [uer_pkg::CFG_IDX_W-1:0] wr_index  = uer_pkg::REG_TRIG_TICKS;
    logic [uer_pkg::DATA_W-1:0]    wr_data   = '0;

    // Predictor copy of the registers and the sequencer state
    logic [uer_pkg::DATA_W-1:0] trig_len     = uer_pkg::TRIG_TICKS_RST;
    logic [uer_pkg::DATA_W-1:0] cm_scale     = uer_pkg::CM_PER_TICK_RST;
    ranger_phase_e              seq_phase    = PH_IDLE;
    logic [15:0]                pulse_cnt    = '0;
    logic [ECHO_COUNT_BITS-1:0] echo_cnt     = '0;
    logic [18:0]                echo_sum     = '0;
    logic [2:0]                 samples_seen = '0;
    logic [uer_pkg::DATA_W-1:0] held_dist    = '0;

    tick_result_t expected_ticks[$];

    bit          idle_on        = 1'b1;
    bit          stall_on       = 1'b1;
    int unsigned mismatch_count = 0;
    int unsigned beat_count     = 0;
    int unsigned done_count     = 0;
    int unsigned cycle_count    = 0;

    ultrasonic_echo_ranger #(
        .SAMPLES    (NUM_SAMPLES),
        .COUNT_BITS (ECHO_COUNT_BITS)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .start_req (start_req),
        .echo      (echo),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .trig      (trig),
        .busy_res  (busy_res),
        .done_res  (done_res),
        .distance  (distance),
        .wr_en     (wr_en),
        .wr_index  (wr_index),
        .wr_data   (wr_data)
    );

    always #(HALF_PERIOD) clk = ~clk;

    // Guard against a hung handshake or a sequencer that never finishes
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb_top NOT OK");
            $finish;
        end
    end

    // Apply one sensor tick to the predictor and return the beat it must produce.
    // The registers are read live, so a write between samples takes effect at once.
    function automatic tick_result_t advance_ranger(input logic start_bit,
                                                    input logic echo_bit);
        tick_result_t               res;
        logic [uer_pkg::DATA_W-1:0] len;
        longint unsigned            quot;
        res = '0;
        // a zero trigger length behaves as a single tick
        len = (trig_len == '0) ? 16'd1 : trig_len;
        case (seq_phase)
            PH_TRIGGER:
            begin
                res.trig  = 1'b1;
                res.busy  = 1'b1;
                pulse_cnt = pulse_cnt + 16'd1;
                if (pulse_cnt >= len)
                begin
                    pulse_cnt = '0;
                    seq_phase = PH_WAIT_ECHO;
                end
            end
            PH_WAIT_ECHO:
            begin
                // no timeout: sit here until the echo rises
                res.busy = 1'b1;
                if (echo_bit)
                begin
                    echo_cnt  = ECHO_COUNT_BITS'(1);
                    seq_phase = PH_COUNT;
                end
            end
            PH_COUNT:
            begin
                if (echo_bit)
                begin
                    res.busy = 1'b1;
                    // hold at full scale rather than wrap on a long echo
                    if (echo_cnt < ECHO_COUNT_MAX)
                        echo_cnt = echo_cnt + 1'b1;
                end
                else
                begin
                    echo_sum     = echo_sum + echo_cnt;
                    echo_cnt     = '0;
                    samples_seen = samples_seen + 3'd1;
                    if (samples_seen >= NUM_SAMPLES || samples_seen == 3'd0)
                    begin
                        // scale, average and round half up, then clamp to 16 bits
                        quot = (64'(echo_sum) * 64'(cm_scale) + (SCALE_DEN >> 1))
                               / SCALE_DEN;
                        held_dist = (quot > 64'd65535) ? 16'hFFFF : quot[15:0];
                        res.done  = 1'b1;
                        seq_phase = PH_IDLE;
                    end
                    else
                    begin
                        res.busy  = 1'b1;
                        pulse_cnt = '0;
                        seq_phase = PH_TRIGGER;
                    end
                end
            end
            default:
            begin
                // a start request counts only here; while busy it is dropped
                seq_phase = PH_IDLE;
                if (start_bit)
                begin
                    res.busy     = 1'b1;
                    echo_sum     = '0;
                    samples_seen = '0;
                    pulse_cnt    = '0;
                    echo_cnt     = '0;
                    seq_phase    = PH_TRIGGER;
                end
            end
        endcase
        res.distance = held_dist;
        return res;
    endfunction

    function automatic void check_field(input string field, input logic [15:0] want_v,
                                        input logic [15:0] got_v);
        if (want_v !== got_v)
        begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
                $display("%0t: %s mismatch, expected %0d, actual %0d",
                         $time, field, want_v, got_v);
        end
    endfunction

    // Receiver side: stall at random, sampled by the block at the next rising edge
    always @(negedge clk)
        out_stall <= stall_on && ($urandom_range(0, 99) < 25);

    // Compare every accepted result beat with the oldest expectation
    always @(posedge clk)
    begin
        tick_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_ticks.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("%0t: result beat with nothing expected, actual %0d/%0d/%0d/%0d",
                             $time, trig, busy_res, done_res, distance);
            end
            else
            begin
                want = expected_ticks.pop_front();
                check_field("trig", 16'(want.trig), 16'(trig));
                check_field("busy_res", 16'(want.busy), 16'(busy_res));
                check_field("done_res", 16'(want.done), 16'(done_res));
                check_field("distance", want.distance, distance);
            end
        end
    end

    // Send one tick. Enter and leave at a falling edge; in_valid is left high so
    // that back-to-back beats need no extra assignment.
    task automatic send_tick(input logic start_bit, input logic echo_bit);
        tick_result_t res;
        while (idle_on && $urandom_range(0, 99) < 25)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid  <= 1'b1;
        start_req <= start_bit;
        echo      <= echo_bit;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        res = advance_ranger(start_bit, echo_bit);
        expected_ticks.push_back(res);
        beat_count++;
        if (res.done)
            done_count++;
        @(negedge clk);
    endtask

    // Stop sending and wait until every expected beat has come back
    task automatic drain_results();
        in_valid <= 1'b0;
        while (expected_ticks.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic cfg_write(input logic [uer_pkg::CFG_IDX_W-1:0] idx,
                             input logic [uer_pkg::DATA_W-1:0] value);
        drain_results();
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= value;
        @(negedge clk);
        wr_en <= 1'b0;
        if (idx == uer_pkg::REG_TRIG_TICKS)
            trig_len = value;
        else if (idx == uer_pkg::REG_CM_PER_TICK)
            cm_scale = value;
    endtask

    // Advance until the sequencer waits for an echo; start it if idle and throw
    // stray start requests and echo noise at every other phase.
    task automatic reach_echo_wait();
        while (seq_phase != PH_WAIT_ECHO)
        begin
            if (seq_phase == PH_IDLE)
                send_tick(1'b1, 1'($urandom_range(0, 1)));
            else
                send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        end
    endtask

    // One measurement: quiet wait, echo high for pulse_len ticks, then low
    task automatic take_sample(input int unsigned pulse_len, input int unsigned quiet_len);
        reach_echo_wait();
        repeat (quiet_len) send_tick(1'($urandom_range(0, 1)), 1'b0);
        repeat (pulse_len) send_tick(1'($urandom_range(0, 1)), 1'b1);
        send_tick(1'($urandom_range(0, 1)), 1'b0);
    endtask

    // Reset values of both registers for the first sample, then a shorter
    // trigger to keep the run brief; a mix of echo widths
    task automatic test_default_registers();
        idle_on  = 1'b1;
        stall_on = 1'b1;
        take_sample(3, 2);
        cfg_write(uer_pkg::REG_TRIG_TICKS, 16'd4);
        take_sample(1, 0);
        take_sample(40, 0);
        take_sample(1, 5);
        take_sample(20, 1);
    endtask

    // Zero and unit trigger lengths against zero and full-scale scaling
    task automatic test_register_extremes();
        cfg_write(uer_pkg::REG_TRIG_TICKS, 16'd0);
        cfg_write(uer_pkg::REG_CM_PER_TICK, 16'd0);
        repeat (NUM_SAMPLES) take_sample($urandom_range(1, 4), 0);
        cfg_write(uer_pkg::REG_TRIG_TICKS, 16'd1);
        cfg_write(uer_pkg::REG_CM_PER_TICK, 16'hFFFF);
        repeat (NUM_SAMPLES) take_sample(1, 0);
    endtask

    // Echo held low for a long while: the sequencer must keep waiting
    task automatic test_echo_held_low();
        cfg_write(uer_pkg::REG_TRIG_TICKS, 16'd2);
        reach_echo_wait();
        repeat (60) send_tick(1'($urandom_range(0, 1)), 1'b0);
        repeat (NUM_SAMPLES) take_sample($urandom_range(1, 30), $urandom_range(0, 3));
    endtask

    // A long echo at full-scale scaling, run flat out on both sides
    task automatic test_long_pulses();
        idle_on  = 1'b0;
        stall_on = 1'b0;
        cfg_write(uer_pkg::REG_TRIG_TICKS, 16'd3);
        cfg_write(uer_pkg::REG_CM_PER_TICK, 16'hFFFF);
        take_sample(200, 0);
        repeat (NUM_SAMPLES - 1) take_sample($urandom_range(1, 20), 0);
        idle_on  = 1'b1;
        stall_on = 1'b1;
    endtask

    // Mostly well-formed measurements with random widths, mixed with noise bursts
    task automatic test_random_traffic();
        int unsigned first_beat;
        int unsigned first_done;
        for (int setting = 0; setting < 4; setting++)
        begin
            case (setting)
                0: cfg_write(uer_pkg::REG_TRIG_TICKS, 16'd0);
                1: cfg_write(uer_pkg::REG_TRIG_TICKS, 16'd1);
                default: cfg_write(uer_pkg::REG_TRIG_TICKS, 16'($urandom_range(2, 6)));
            endcase
            if (setting == 1)
                cfg_write(uer_pkg::REG_CM_PER_TICK, 16'hFFFF);
            else
                cfg_write(uer_pkg::REG_CM_PER_TICK, 16'($urandom_range(0, 65535)));
            first_beat = beat_count;
            first_done = done_count;
            while ((beat_count - first_beat < 60 || done_count - first_done < 1)
                   && beat_count - first_beat < 400)
            begin
                if ($urandom_range(0, 99) < 80)
                begin
                    if ($urandom_range(0, 99) < 85)
                        take_sample($urandom_range(1, 12), $urandom_range(0, 4));
                    else
                        take_sample($urandom_range(13, 60), $urandom_range(0, 4));
                end
                else
                begin
                    repeat ($urandom_range(1, 8))
                        send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
                end
            end
        end
    endtask

    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_default_registers();
        test_register_extremes();
        test_echo_held_low();
        test_long_pulses();
        test_random_traffic();

        drain_results();
        if (mismatch_count == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule
